### design/trcq_pkg.sv
// ----------------------------------------------------------------------------
// Tile map collision query package
// Shared constants, operation codes and register indexes for the tile map
// collision query block and its checker.
// ----------------------------------------------------------------------------
package trcq_pkg;

   // Default store dimensions.
   localparam int TRCQ_MAX_COLS   = 64;
   localparam int TRCQ_MAX_ROWS   = 64;
   localparam int TRCQ_MAX_LAYERS = 4;

   // Register port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register field widths.
   localparam int TILE_SHIFT_W = 3;
   localparam int MAP_DIM_W    = 7;
   localparam int LAYERS_W     = 3;

   // Register values after reset.
   localparam logic [TILE_SHIFT_W-1:0] TILE_SHIFT_RST  = 3'd5;
   localparam logic [MAP_DIM_W-1:0]    MAP_COLS_RST    = 7'd60;
   localparam logic [MAP_DIM_W-1:0]    MAP_ROWS_RST    = 7'd20;
   localparam logic [LAYERS_W-1:0]     LAYERS_USED_RST = 3'd1;

   // Transaction operation codes.
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_BOX    = 2'd1,
      OP_CIRCLE = 2'd2
   } opcode_type;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_TILE_SHIFT  = 2'd0,
      REG_MAP_COLS    = 2'd1,
      REG_MAP_ROWS    = 2'd2,
      REG_LAYERS_USED = 2'd3
   } csr_reg_type;

endpackage

### design/trcq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module trcq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tilemap_region_collision_query.sv
// ----------------------------------------------------------------------------
// Tile map region collision query
// Layered solid-tile map with box and circle overlap queries.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A tile write
// gives no result; busy stays low. A box or circle query keeps busy high
// through a setup and a bound step, then for each tile column visited a
// squaring step and for each tile visited in the clamped rectangle a read
// and a check step; the scan stops at the first solid tile that is covered,
// and a query whose rectangle misses the map in use ends after the bound
// step. The scan is paced by the single squaring multiplier (one square per
// column, one per tile) and by the single read port of each layer RAM,
// whose read is registered. The result appears on rsp_hit, marked by
// rsp_valid for exactly one cycle, in the cycle in which busy falls; the
// receiver cannot stall it, so it must sample rsp_hit whenever rsp_valid is
// high. Opcode 3 is taken and dropped. After reset the block runs a clearing
// pass over all 2**(clog2(MAX_ROWS) + clog2(MAX_COLS)) store entries (4096
// at the default size), one entry per cycle; busy is high during it, and
// register writes are accepted as usual.
// ----------------------------------------------------------------------------
module tilemap_region_collision_query
   import trcq_pkg::*;
#(
   parameter int MAX_COLS   = TRCQ_MAX_COLS,
   parameter int MAX_ROWS   = TRCQ_MAX_ROWS,
   parameter int MAX_LAYERS = TRCQ_MAX_LAYERS
) (
   input  logic                  clock,
   input  logic                  reset,
   // Transaction input
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [1:0]            req_layer_sel,
   input  logic [5:0]            req_tile_col,
   input  logic [5:0]            req_tile_row,
   input  logic [15:0]           req_tile_value,
   input  logic signed [15:0]    req_pos_x,
   input  logic signed [15:0]    req_pos_y,
   input  logic [11:0]           req_box_width,
   input  logic [11:0]           req_box_height,
   input  logic [11:0]           req_radius,
   // Result output
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   // Register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int DEPTH  = 1 << ADDR_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_BOUND = 7'b0001000,
      ST_COLSQ = 7'b0010000,
      ST_SCAN  = 7'b0100000,
      ST_CHECK = 7'b1000000
   } state_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [TILE_SHIFT_W-1:0] tile_shift_ff, tile_shift_in;
   logic [MAP_DIM_W-1:0]    map_cols_ff, map_cols_in;
   logic [MAP_DIM_W-1:0]    map_rows_ff, map_rows_in;
   logic [LAYERS_W-1:0]     layers_used_ff, layers_used_in;
   logic                    csr_wr;
   csr_reg_type             csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      tile_shift_in  = tile_shift_ff;
      map_cols_in    = map_cols_ff;
      map_rows_in    = map_rows_ff;
      layers_used_in = layers_used_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_TILE_SHIFT:  tile_shift_in  = pwdata[TILE_SHIFT_W-1:0];
            REG_MAP_COLS:    map_cols_in    = pwdata[MAP_DIM_W-1:0];
            REG_MAP_ROWS:    map_rows_in    = pwdata[MAP_DIM_W-1:0];
            REG_LAYERS_USED: layers_used_in = pwdata[LAYERS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TILE_SHIFT:  prdata = CSR_DATA_W'(tile_shift_ff);
         REG_MAP_COLS:    prdata = CSR_DATA_W'(map_cols_ff);
         REG_MAP_ROWS:    prdata = CSR_DATA_W'(map_rows_ff);
         REG_LAYERS_USED: prdata = CSR_DATA_W'(layers_used_ff);
         default:         prdata = '0;
      endcase
   end

   // Register values above the store size saturate to it.
   logic [MAP_DIM_W-1:0] cols_eff, rows_eff;
   logic [LAYERS_W-1:0]  layers_eff;

   assign cols_eff   = (9'(map_cols_ff) > 9'(MAX_COLS)) ? MAP_DIM_W'(MAX_COLS) : map_cols_ff;
   assign rows_eff   = (9'(map_rows_ff) > 9'(MAX_ROWS)) ? MAP_DIM_W'(MAX_ROWS) : map_rows_ff;
   assign layers_eff = (4'(layers_used_ff) > 4'(MAX_LAYERS)) ?
                       LAYERS_W'(MAX_LAYERS) : layers_used_ff;

   // ------------------------------------------------------------------
   // Sequencer state and working registers
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;

   logic                 circle_ff, circle_in;
   logic signed [15:0]   x_ff, x_in;
   logic signed [15:0]   y_ff, y_in;
   logic [11:0]          ext_x_ff, ext_x_in;   // width or radius
   logic [11:0]          ext_y_ff, ext_y_in;   // height or radius
   logic signed [16:0]   elo_c_ff, elo_c_in;
   logic signed [16:0]   ehi_c_ff, ehi_c_in;
   logic signed [16:0]   elo_r_ff, elo_r_in;
   logic signed [16:0]   ehi_r_ff, ehi_r_in;
   logic [23:0]          r2_ff, r2_in;
   logic [31:0]          dx2_ff, dx2_in;
   logic [31:0]          dy2_ff, dy2_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [COL_W-1:0]     hi_c_ff, hi_c_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROW_W-1:0]     lo_r_ff, lo_r_in;
   logic [ROW_W-1:0]     hi_r_ff, hi_r_in;

   logic accept;
   logic clearing;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // ------------------------------------------------------------------
   // Shared squaring unit: r*r during setup, dx*dx once per column and
   // dy*dy once per tile. Its result is always registered.
   // ------------------------------------------------------------------
   logic [17:0]        half_px;
   logic [17:0]        col_px, row_px;
   logic signed [17:0] dx, dy;
   logic signed [17:0] mul_op;
   logic signed [35:0] sq_full;
   logic [31:0]        sq;

   assign half_px = (18'd1 << tile_shift_ff) >> 1;
   assign col_px  = 18'(col_ff) << tile_shift_ff;
   assign row_px  = 18'(row_ff) << tile_shift_ff;
   assign dx      = $signed(col_px + half_px) - $signed({{2{x_ff[15]}}, x_ff});
   assign dy      = $signed(row_px + half_px) - $signed({{2{y_ff[15]}}, y_ff});

   always_comb begin
      case (state_ff)
         ST_COLSQ: mul_op = dx;
         ST_SCAN:  mul_op = dy;
         default:  mul_op = $signed({6'b0, ext_x_ff});
      endcase
   end

   assign sq_full = mul_op * mul_op;
   assign sq      = sq_full[31:0];

   // ------------------------------------------------------------------
   // Tile store: one single-bit RAM per layer, addressed {row, col}.
   // ------------------------------------------------------------------
   logic                  wr_ok;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  wr_bit;
   logic [ADDR_W-1:0]     rd_addr;
   logic [MAX_LAYERS-1:0] layer_we;
   logic [MAX_LAYERS-1:0] rd_bits;
   logic [MAX_LAYERS-1:0] layer_mask;

   // Writes outside the store are dropped.
   assign wr_ok   = accept && (req_opcode == OP_WRITE) &&
                    (9'(req_tile_col) < 9'(MAX_COLS)) &&
                    (9'(req_tile_row) < 9'(MAX_ROWS)) &&
                    (4'(req_layer_sel) < 4'(MAX_LAYERS));
   assign wr_addr = clearing ? clr_ff : {ROW_W'(req_tile_row), COL_W'(req_tile_col)};
   assign wr_bit  = !clearing && (req_tile_value != '0);
   assign rd_addr = {row_ff, col_ff};

   for (genvar l = 0; l < MAX_LAYERS; l++) begin : g_layer
      assign layer_we[l]   = clearing || (wr_ok && (4'(req_layer_sel) == 4'(l)));
      assign layer_mask[l] = (4'(l) < 4'(layers_eff));

      trcq_ram #(
         .WIDTH (1),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (layer_we[l]),
         .wr_addr (wr_addr),
         .wr_data (wr_bit),
         .rd_addr (rd_addr),
         .rd_data (rd_bits[l])
      );
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   logic signed [16:0] sx, sy, ex, ey;
   logic signed [16:0] lo_x_sum, hi_x_sum, lo_y_sum, hi_y_sum;
   logic signed [16:0] cols_m1, rows_m1;
   logic               empty;
   logic               in_range;
   logic               tile_hit;

   assign sx = $signed({x_ff[15], x_ff});
   assign sy = $signed({y_ff[15], y_ff});
   assign ex = $signed({5'b0, ext_x_ff});
   assign ey = $signed({5'b0, ext_y_ff});
   // A box spans [x, x + w]; a circle's bounding box spans [x - r, x + r].
   assign lo_x_sum = circle_ff ? (sx - ex) : sx;
   assign hi_x_sum = sx + ex;
   assign lo_y_sum = circle_ff ? (sy - ey) : sy;
   assign hi_y_sum = sy + ey;

   assign cols_m1 = $signed({10'b0, cols_eff}) - 17'sd1;
   assign rows_m1 = $signed({10'b0, rows_eff}) - 17'sd1;

   // The rectangle is empty when it lies wholly off the map in use, or when
   // the map or the layer count is zero.
   assign empty = (cols_eff == '0) || (rows_eff == '0) || (layers_eff == '0) ||
                  ehi_c_ff[16] || ehi_r_ff[16] ||
                  (elo_c_ff > cols_m1) || (elo_r_ff > rows_m1);

   assign in_range = !circle_ff ||
                     ((33'(dx2_ff) + 33'(dy2_ff)) <= 33'(r2_ff));
   assign tile_hit = in_range && (|(rd_bits & layer_mask));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      circle_in    = circle_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ext_x_in     = ext_x_ff;
      ext_y_in     = ext_y_ff;
      elo_c_in     = elo_c_ff;
      ehi_c_in     = ehi_c_ff;
      elo_r_in     = elo_r_ff;
      ehi_r_in     = ehi_r_ff;
      r2_in        = r2_ff;
      dx2_in       = dx2_ff;
      dy2_in       = dy2_ff;
      col_in       = col_ff;
      hi_c_in      = hi_c_ff;
      row_in       = row_ff;
      lo_r_in      = lo_r_ff;
      hi_r_in      = hi_r_ff;

      case (state_ff)
         ST_IDLE: begin
            // Tile writes go straight to the RAMs; only queries leave idle.
            if (start && ((req_opcode == OP_BOX) || (req_opcode == OP_CIRCLE))) begin
               circle_in = (req_opcode == OP_CIRCLE);
               x_in      = req_pos_x;
               y_in      = req_pos_y;
               ext_x_in  = (req_opcode == OP_CIRCLE) ? req_radius : req_box_width;
               ext_y_in  = (req_opcode == OP_CIRCLE) ? req_radius : req_box_height;
               state_in  = ST_SETUP;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            // Arithmetic shift gives the floor of the pixel-to-tile division.
            elo_c_in = lo_x_sum >>> tile_shift_ff;
            ehi_c_in = hi_x_sum >>> tile_shift_ff;
            elo_r_in = lo_y_sum >>> tile_shift_ff;
            ehi_r_in = hi_y_sum >>> tile_shift_ff;
            r2_in    = sq[23:0];
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            if (empty) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               col_in   = elo_c_ff[16] ? '0 : elo_c_ff[COL_W-1:0];
               hi_c_in  = (ehi_c_ff > cols_m1) ? cols_m1[COL_W-1:0] : ehi_c_ff[COL_W-1:0];
               row_in   = elo_r_ff[16] ? '0 : elo_r_ff[ROW_W-1:0];
               lo_r_in  = elo_r_ff[16] ? '0 : elo_r_ff[ROW_W-1:0];
               hi_r_in  = (ehi_r_ff > rows_m1) ? rows_m1[ROW_W-1:0] : ehi_r_ff[ROW_W-1:0];
               state_in = ST_COLSQ;
            end
         end
         ST_COLSQ: begin
            dx2_in   = sq;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // The tile's layer bits are read this cycle and land next cycle.
            dy2_in   = sq;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (tile_hit) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               state_in     = ST_IDLE;
            end else if (row_ff == hi_r_ff) begin
               if (col_ff == hi_c_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  row_in   = lo_r_ff;
                  state_in = ST_COLSQ;
               end
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         tile_shift_ff  <= TILE_SHIFT_RST;
         map_cols_ff    <= MAP_COLS_RST;
         map_rows_ff    <= MAP_ROWS_RST;
         layers_used_ff <= LAYERS_USED_RST;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         tile_shift_ff  <= tile_shift_in;
         map_cols_ff    <= map_cols_in;
         map_rows_ff    <= map_rows_in;
         layers_used_ff <= layers_used_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      circle_ff  <= circle_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      ext_x_ff   <= ext_x_in;
      ext_y_ff   <= ext_y_in;
      elo_c_ff   <= elo_c_in;
      ehi_c_ff   <= ehi_c_in;
      elo_r_ff   <= elo_r_in;
      ehi_r_ff   <= ehi_r_in;
      r2_ff      <= r2_in;
      dx2_ff     <= dx2_in;
      dy2_ff     <= dy2_in;
      col_ff     <= col_in;
      hi_c_ff    <= hi_c_in;
      row_ff     <= row_in;
      lo_r_ff    <= lo_r_in;
      hi_r_ff    <= hi_r_in;
   end

endmodule

### design/trcq_checker.sv
// ----------------------------------------------------------------------------
// Tile map collision query checker
// Port-level assertions on transaction handling and the result strobe.
// ----------------------------------------------------------------------------
module trcq_checker
   import trcq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_opcode,
   input logic       rsp_valid
);

   logic taken;

   assign taken = start && !busy;

   // A tile write leaves busy low and never yields a result.
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      taken && (req_opcode == OP_WRITE) |=> !busy && !rsp_valid)
      else $error("tile write produced a result or raised busy");

   // An accepted query always raises busy.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      taken && ((req_opcode == OP_BOX) || (req_opcode == OP_CIRCLE)) |=> busy)
      else $error("query accepted without raising busy");

   // The unused opcode is dropped without effect.
   a_unused_dropped: assert property (@(posedge clock) disable iff (reset)
      taken && (req_opcode != OP_WRITE) && (req_opcode != OP_BOX) &&
      (req_opcode != OP_CIRCLE) |=> !busy && !rsp_valid)
      else $error("unused opcode was not dropped");

   // A result is shown only once the block has gone back to idle.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // One result per query: the strobe is never held high.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

bind tilemap_region_collision_query trcq_checker u_trcq_checker (.*);
